// ===== src/rb2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// rb2rgb_pkg: shared types and constants
// Payload structs, register codes and fixed widths of the RAW12 binning block.
// ----------------------------------------------------------------------------
package rb2rgb_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned ENTRY_BITS  = 2 * SAMPLE_BITS;
  localparam int unsigned COL_BITS    = 11;
  localparam int unsigned ROW_BITS    = 12;
  localparam int unsigned PAIRS_BITS  = 12;
  localparam int unsigned ROWS_BITS   = 13;
  localparam int unsigned CFG_BITS    = 13;

  localparam logic [PAIRS_BITS-1:0] PAIRS_RESET = 12'd2048;
  localparam logic [ROWS_BITS-1:0]  ROWS_RESET  = 13'd3072;
  localparam logic [ROWS_BITS-1:0]  ROWS_MIN    = 13'd2;
  localparam logic [ROWS_BITS-1:0]  ROWS_MAX    = 13'd4096;

  // floor(9*s/20) = floor(floor(9*s/4) * 52429 / 2^18), exact while floor(9*s/4) < 2^18
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + 1;
  localparam int unsigned X9_BITS     = SUM_BITS + 4;
  localparam int unsigned QUART_BITS  = X9_BITS - 2;
  localparam int unsigned RECIP_BITS  = 16;
  localparam int unsigned PROD_BITS   = QUART_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] GREEN_RECIP = 16'd52429;
  localparam int unsigned GREEN_SHIFT = 18;
  localparam logic [SAMPLE_BITS-1:0] GREEN_MAX = 12'd3685;

  typedef enum logic [0:0] {
    CFG_PAIRS_PER_ROW  = 1'b0,
    CFG_ROWS_PER_FRAME = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] middle_byte;
    logic [7:0] final_byte;
  } raw_group_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_value;
    logic [SAMPLE_BITS-1:0] green_value;
    logic [SAMPLE_BITS-1:0] blue_value;
    logic                   row_end;
    logic                   frame_end;
  } rgb_pixel_t;

endpackage

// ===== src/rb2rgb_if.sv =====
// ----------------------------------------------------------------------------
// rb2rgb channel interfaces
// Valid/ready channels for packed RAW12 groups and binned RGB pixels.
// ----------------------------------------------------------------------------
interface rb2rgb_raw_if;
  logic                   valid;
  logic                   ready;
  rb2rgb_pkg::raw_group_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rb2rgb_pix_if;
  logic                   valid;
  logic                   ready;
  rb2rgb_pkg::rgb_pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/raw12_bayer_bin_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// raw12_bayer_bin_to_rgb_top: RAW12 RGGB unpack and 2x2 binning to RGB
// Throughput: one packed group per cycle; only a held output pixel stalls intake.
// An odd-row item passes the stage 1, 2 and 3 registers and the output register.
// Even-row items write the line store and give no pixel.
// Reset: counters to row 0 / column 0, registers to 2048 groups, 3072 rows;
//   line store is not cleared and holds nothing until an even row writes it.
// ----------------------------------------------------------------------------
module raw12_bayer_bin_to_rgb_top #(
  parameter int unsigned MAX_PAIRS_PER_ROW = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [rb2rgb_pkg::CFG_BITS-1:0]   cfg_data_i,
  rb2rgb_raw_if.sink                        raw_if,
  rb2rgb_pix_if.source                      pix_if
);

  localparam int unsigned SB = rb2rgb_pkg::SAMPLE_BITS;

  // Line-store address; column index modulo the store depth
  localparam int unsigned SLOT_BITS =
    (MAX_PAIRS_PER_ROW > 1) ? $clog2(MAX_PAIRS_PER_ROW) : 1;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(MAX_PAIRS_PER_ROW - 1);

  // Width for comparing column count against the clamped group count
  localparam int unsigned CNT_BITS =
    ($clog2(MAX_PAIRS_PER_ROW + 1) > rb2rgb_pkg::PAIRS_BITS) ?
    $clog2(MAX_PAIRS_PER_ROW + 1) : rb2rgb_pkg::PAIRS_BITS;
  localparam logic [CNT_BITS-1:0] PAIRS_LIMIT = CNT_BITS'(MAX_PAIRS_PER_ROW);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rb2rgb_pkg::PAIRS_BITS-1:0] pairs_q;
  logic [rb2rgb_pkg::ROWS_BITS-1:0]  rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= rb2rgb_pkg::PAIRS_RESET;
      rows_q  <= rb2rgb_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      case (rb2rgb_pkg::cfg_idx_e'(cfg_idx_i))
        rb2rgb_pkg::CFG_PAIRS_PER_ROW: begin
          pairs_q <= cfg_data_i[rb2rgb_pkg::PAIRS_BITS-1:0];
        end
        rb2rgb_pkg::CFG_ROWS_PER_FRAME: begin
          rows_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Registers in use: group count clamped to 1..max, row count to 2..4096, even
  logic [CNT_BITS-1:0]               pairs_ext;
  logic [CNT_BITS-1:0]               pairs_used;
  logic [rb2rgb_pkg::ROWS_BITS-1:0]  rows_clamp;
  logic [rb2rgb_pkg::ROWS_BITS-1:0]  rows_used;

  assign pairs_ext  = CNT_BITS'(pairs_q);
  assign pairs_used = (pairs_q == '0) ? CNT_BITS'(1) :
                      ((pairs_ext > PAIRS_LIMIT) ? PAIRS_LIMIT : pairs_ext);
  assign rows_clamp = (rows_q < rb2rgb_pkg::ROWS_MIN) ? rb2rgb_pkg::ROWS_MIN :
                      ((rows_q > rb2rgb_pkg::ROWS_MAX) ? rb2rgb_pkg::ROWS_MAX : rows_q);
  assign rows_used  = {rows_clamp[rb2rgb_pkg::ROWS_BITS-1:1], 1'b0};

  // ---------------------------------------------------------------------------
  // Handshake. One global advance: every stage moves when the output register
  // is empty or being drained, so a pixel held there also stalls intake.
  // ---------------------------------------------------------------------------
  logic adv;
  logic acc;
  logic out_v_q;

  assign adv          = !out_v_q || pix_if.ready;
  assign raw_if.ready = adv;
  assign acc          = raw_if.valid && adv;

  // ---------------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------------
  logic [rb2rgb_pkg::COL_BITS-1:0]  col_q, col_d;
  logic [rb2rgb_pkg::ROW_BITS-1:0]  row_q, row_d;
  logic [SLOT_BITS-1:0]             slot_q, slot_d;
  logic [rb2rgb_pkg::COL_BITS:0]    col_inc;
  logic [rb2rgb_pkg::ROWS_BITS-1:0] row_inc;
  logic                             last_col;
  logic                             last_row;
  logic                             odd_row;

  assign odd_row  = row_q[0];
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign last_col = CNT_BITS'(col_inc) >= pairs_used;
  assign last_row = row_inc >= rows_used;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (acc) begin
      if (last_col) begin
        col_d  = '0;
        slot_d = '0;
        row_d  = last_row ? '0 : row_inc[rb2rgb_pkg::ROW_BITS-1:0];
      end else begin
        col_d = col_inc[rb2rgb_pkg::COL_BITS-1:0];
        // slot follows column modulo depth; column wrap restarts it too
        if (col_d == '0 || slot_q == SLOT_LAST) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Unpack and line store. Even rows write (red, green), odd rows read them.
  // An item is either a write or a read, never both; the earliest read of an
  // entry comes the cycle after its write, so the RAM already holds it.
  // ---------------------------------------------------------------------------
  logic [SB-1:0]                     samp_one;
  logic [SB-1:0]                     samp_two;
  logic [rb2rgb_pkg::ENTRY_BITS-1:0] rd_entry;

  assign samp_one = {raw_if.data.first_byte, raw_if.data.middle_byte[7:4]};
  assign samp_two = {raw_if.data.middle_byte[3:0], raw_if.data.final_byte};

  rb2rgb_ram #(
    .WIDTH (rb2rgb_pkg::ENTRY_BITS),
    .DEPTH (MAX_PAIRS_PER_ROW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (acc && !odd_row),
    .waddr_i (slot_q),
    .wdata_i ({samp_one, samp_two}),
    .re_i    (acc && odd_row),
    .raddr_i (slot_q),
    .rdata_o (rd_entry)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: RAM read in flight; odd-row green and blue held alongside
  // ---------------------------------------------------------------------------
  logic          v1_q, v2_q, v3_q;
  logic [SB-1:0] godd1_q, blue1_q;
  logic          re1_q, fe1_q;

  // Stage 2: green sum scaled by 9/4
  logic [rb2rgb_pkg::SUM_BITS-1:0]   gsum;
  logic [rb2rgb_pkg::X9_BITS-1:0]    gx9;
  logic [SB-1:0]                     red2_q, blue2_q;
  logic [rb2rgb_pkg::QUART_BITS-1:0] gq2_q;
  logic                              re2_q, fe2_q;

  // Stage 3: divide by 5 through the reciprocal product
  logic [SB-1:0]                     red3_q, blue3_q;
  logic [rb2rgb_pkg::PROD_BITS-1:0]  prod3_q;
  logic                              re3_q, fe3_q;

  rb2rgb_pkg::rgb_pixel_t            pix_q;

  assign gsum = rb2rgb_pkg::SUM_BITS'(rd_entry[SB-1:0]) + rb2rgb_pkg::SUM_BITS'(godd1_q);
  assign gx9  = rb2rgb_pkg::X9_BITS'({gsum, 3'b000}) + rb2rgb_pkg::X9_BITS'(gsum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= acc && odd_row;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      godd1_q <= samp_one;
      blue1_q <= samp_two;
      re1_q   <= last_col;
      fe1_q   <= last_col && last_row;

      red2_q  <= rd_entry[rb2rgb_pkg::ENTRY_BITS-1:SB];
      gq2_q   <= gx9[rb2rgb_pkg::X9_BITS-1:2];
      blue2_q <= blue1_q;
      re2_q   <= re1_q;
      fe2_q   <= fe1_q;

      red3_q  <= red2_q;
      prod3_q <= rb2rgb_pkg::PROD_BITS'(gq2_q) *
                 rb2rgb_pkg::PROD_BITS'(rb2rgb_pkg::GREEN_RECIP);
      blue3_q <= blue2_q;
      re3_q   <= re2_q;
      fe3_q   <= fe2_q;

      pix_q.red_value   <= red3_q;
      pix_q.green_value <= prod3_q[rb2rgb_pkg::GREEN_SHIFT +: SB];
      pix_q.blue_value  <= blue3_q;
      pix_q.row_end     <= re3_q;
      pix_q.frame_end   <= fe3_q;
    end
  end

  assign pix_if.valid = out_v_q;
  assign pix_if.data  = pix_q;

`ifndef ASSERT_OFF
  a_even_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !odd_row |=> !v1_q)
    else $error("even-row item entered the pixel pipeline");

  a_odd_makes_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && odd_row |=> v1_q)
    else $error("odd-row item lost before the pipeline");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_col && last_row |=> col_q == '0 && row_q == '0)
    else $error("frame did not wrap to origin");

  a_green_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> pix_q.green_value <= rb2rgb_pkg::GREEN_MAX)
    else $error("green result above 0.45 of full-scale sum");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("line-store address beyond depth");
`endif

endmodule

// ===== src/rb2rgb_ram.sv =====
// ----------------------------------------------------------------------------
// rb2rgb_ram: simple dual-port RAM
// One write port, one read port, read data registered; held when not reading.
// ----------------------------------------------------------------------------
module rb2rgb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
